>>> design/rank_bitmap_assert.svh
// assertion macros for the rank bitmap checker
`ifndef RANK_BITMAP_ASSERT_SVH
`define RANK_BITMAP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rank_bitmap check failed");

// next-cycle implication, disabled while reset is low
`define RB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rank_bitmap check failed");

`endif

>>> design/rb_pkg.sv
// shared types, constants and the popcount function of the rank bitmap
package rb_pkg;

    localparam int WORD_BITS       = 32;
    localparam int BIT_W           = 5;
    localparam int MEMBER_BITS_DEF = 4096;
    localparam int MODE_W          = 2;
    localparam int VALUE_W         = 12;
    localparam int RANK_W          = 12;
    localparam int SUM_W           = RANK_W + 1;
    localparam int POP_W           = 6;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 12'hFFF;
    localparam logic [RANK_W-1:0]  RANK_MAX      = 12'hFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_TEST  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_RANK  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_RANK,
        ST_DONE
    } t_state;

    function automatic logic [POP_W-1:0] pop32(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] c;
        logic [WORD_BITS-1:0] d;
        logic [WORD_BITS-1:0] e;
        a = (w & 32'h5555_5555) + ((w >> 1) & 32'h5555_5555);
        b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
        c = (b & 32'h0F0F_0F0F) + ((b >> 4) & 32'h0F0F_0F0F);
        d = (c & 32'h00FF_00FF) + ((c >> 8) & 32'h00FF_00FF);
        e = (d & 32'h0000_FFFF) + ((d >> 16) & 32'h0000_FFFF);
        return e[POP_W-1:0];
    endfunction

endpackage

>>> design/rank_bitmap.sv
// rank bitmap: membership bits in one word memory, test / set / clear / rank
// steps: an item is accepted in ST_IDLE, its word is read in ST_LOOK and the result is registered in ST_DONE;
//   a value above the limit goes from ST_IDLE straight to ST_DONE, a rank of a member via ST_RANK
// throughput: one word memory read per cycle; rank walks words 0 .. v/32 in sequence,
//   and a new item is accepted only in ST_IDLE, once ST_DONE has handed on the last result
// reset: a clearing pass writes zero to all MEMBER_BITS/32 words
//   while no item is accepted; the limit register returns to 4095
module rank_bitmap #(
    parameter int MEMBER_BITS = rb_pkg::MEMBER_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rb_pkg::VALUE_W-1:0]   i_cfg_data,    // max_value
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // mode [1:0], value [13:2]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rb_pkg::M_TDATA_W-1:0] m_axis_tdata   // ok [0], rank [12:1]
);
    import rb_pkg::*;

    localparam int WORD_COUNT = MEMBER_BITS / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    t_state               r_state, n_state;
    t_mode                r_mode, n_mode;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [ADDR_W-1:0]    r_idx, n_idx;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic                 r_ok, n_ok;
    logic [RANK_W-1:0]    r_rank, n_rank;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_ok, n_out_ok;
    logic [RANK_W-1:0]    r_out_rank, n_out_rank;
    logic [VALUE_W-1:0]   r_max;
    logic [WORD_BITS-1:0] r_rdata;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [MODE_W-1:0]    in_mode;
    logic [VALUE_W-1:0]   in_value;
    logic                 in_range;
    logic [ADDR_W-1:0]    in_word;
    logic [ADDR_W-1:0]    cur_word;
    logic [BIT_W-1:0]     cur_bit;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 hit;
    logic [WORD_BITS-1:0] rank_word;
    logic [SUM_W-1:0]     sum_next;

    assign in_mode  = s_axis_tdata[MODE_W-1:0];
    assign in_value = s_axis_tdata[MODE_W +: VALUE_W];
    assign in_range = (in_value <= r_max) && (32'(in_value) < 32'(MEMBER_BITS));
    assign in_word  = ADDR_W'(in_value[VALUE_W-1:BIT_W]);

    assign cur_word  = ADDR_W'(r_value[VALUE_W-1:BIT_W]);
    assign cur_bit   = r_value[BIT_W-1:0];
    assign bit_mask  = WORD_BITS'(1) << cur_bit;
    assign hit       = r_rdata[cur_bit];
    assign rank_word = (r_idx == cur_word) ? (r_rdata & (bit_mask - WORD_BITS'(1))) : r_rdata;
    assign sum_next  = r_sum + SUM_W'(pop32(rank_word));

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_rank, r_out_ok});

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_value     = r_value;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_ok        = r_ok;
        n_rank      = r_rank;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ok    = r_out_ok;
        n_out_rank  = r_out_rank;
        rd_en       = 1'b0;
        rd_addr     = in_word;
        wr_en       = 1'b0;
        wr_addr     = cur_word;
        wr_data     = r_rdata;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = '0;
                n_idx   = r_idx + ADDR_W'(1);
                if (r_idx == ADDR_W'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = t_mode'(in_mode);
                    n_value = in_value;
                    n_ok    = 1'b0;
                    n_rank  = '0;
                    if (in_range) begin
                        rd_en   = 1'b1;
                        n_state = ST_LOOK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_LOOK: begin
                n_state = ST_DONE;
                case (r_mode)
                    MODE_TEST: begin
                        n_ok = hit;
                    end
                    MODE_SET: begin
                        if (!hit) begin
                            wr_en   = 1'b1;
                            wr_data = r_rdata | bit_mask;
                            n_ok    = 1'b1;
                        end
                    end
                    MODE_CLEAR: begin
                        if (hit) begin
                            wr_en   = 1'b1;
                            wr_data = r_rdata & ~bit_mask;
                            n_ok    = 1'b1;
                        end
                    end
                    MODE_RANK: begin
                        if (hit) begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                            n_sum   = '0;
                            n_state = ST_RANK;
                        end
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            ST_RANK: begin
                n_sum = sum_next;
                if (r_idx == cur_word) begin
                    n_ok    = 1'b1;
                    n_rank  = (sum_next > SUM_W'(RANK_MAX)) ? RANK_MAX : sum_next[RANK_W-1:0];
                    n_state = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + ADDR_W'(1);
                    n_idx   = r_idx + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_rank  = r_rank;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_max       <= MAX_VALUE_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_value    <= n_value;
        r_sum      <= n_sum;
        r_ok       <= n_ok;
        r_rank     <= n_rank;
        r_out_ok   <= n_out_ok;
        r_out_rank <= n_out_rank;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

endmodule

>>> design/rb_chk.sv
// port-level checker of the rank bitmap and its bind
`include "rank_bitmap_assert.svh"

module rb_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rb_pkg::*;

    // a result waiting at the output keeps its payload
    `RB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a rank count only comes with ok
    `RB_ASSERT_IMP(a_rank_needs_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[RANK_W:1] == '0)

    // one item at a time
    `RB_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // the clearing pass holds off input right after reset
    `RB_ASSERT_IMP(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !s_axis_tready)

endmodule

bind rank_bitmap rb_chk u_rb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/rank_bitmap_tb.sv
// self-checking testbench for rank_bitmap: directed and random items against a bitmap predictor
module rank_bitmap_tb;
    import rb_pkg::*;

    localparam int WORD_COUNT  = MEMBER_BITS_DEF / WORD_BITS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 4 + WORD_COUNT + 8;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              ok;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [VALUE_W-1:0]   i_cfg_data = '0;        // max_value
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;      // mode [1:0], value [13:2]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;           // ok [0], rank [12:1]

    logic [WORD_BITS-1:0] member_words [WORD_COUNT];
    logic [VALUE_W-1:0]   value_limit = MAX_VALUE_RST;
    t_answer              pending_answers [$];
    t_answer              oldest_answer;
    t_answer              seen_answer;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   stall_left = 0;
    bit                   sender_idles = 1'b0;
    bit                   receiver_idles = 1'b0;

    rank_bitmap dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // membership update and rank over the shadow bitmap
    function automatic t_answer bitmap_lookup(input t_mode op, input logic [VALUE_W-1:0] v);
        t_answer     a;
        int unsigned total;
        int          w;
        int          b;
        logic        allowed;
        logic        hit;
        a = '0;
        w = v / WORD_BITS;
        b = v % WORD_BITS;
        allowed = (v <= value_limit);
        hit = allowed && member_words[w][b];
        case (op)
            MODE_TEST: a.ok = hit;
            MODE_SET: begin
                if (allowed && !hit) begin
                    member_words[w][b] = 1'b1;
                    a.ok = 1'b1;
                end
            end
            MODE_CLEAR: begin
                if (hit) begin
                    member_words[w][b] = 1'b0;
                    a.ok = 1'b1;
                end
            end
            default: begin
                if (hit) begin
                    total = 0;
                    for (int i = 0; i < w; i++)
                        total += $countones(member_words[i]);
                    total += $countones(member_words[w] & ((32'd1 << b) - 32'd1));
                    a.ok = 1'b1;
                    a.rank = (total > RANK_MAX) ? RANK_MAX : total[RANK_W-1:0];
                end
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] %s: got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input t_mode op, input logic [VALUE_W-1:0] v);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, v, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(bitmap_lookup(op, v));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic write_limit(input logic [VALUE_W-1:0] lim);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        value_limit = lim;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_answer = m_axis_tdata[RANK_W:0];
            if (pending_answers.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (seen_answer.ok !== oldest_answer.ok)
                    report_mismatch("ok", int'(seen_answer.ok), int'(oldest_answer.ok));
                if (seen_answer.rank !== oldest_answer.rank)
                    report_mismatch("rank", int'(seen_answer.rank), int'(oldest_answer.rank));
            end
        end
    end

    task automatic test_basic_ops();
        write_limit(MAX_VALUE_RST);
        send_item(MODE_TEST, 12'd0);
        send_item(MODE_RANK, 12'd0);
        send_item(MODE_SET, 12'd0);
        send_item(MODE_SET, 12'd0);
        send_item(MODE_TEST, 12'd0);
        send_item(MODE_RANK, 12'd0);
        send_item(MODE_SET, 12'd4095);
        send_item(MODE_RANK, 12'd4095);
        send_item(MODE_SET, 12'd31);
        send_item(MODE_SET, 12'd32);
        send_item(MODE_RANK, 12'd33);
        send_item(MODE_RANK, 12'd32);
        send_item(MODE_CLEAR, 12'd0);
        send_item(MODE_CLEAR, 12'd0);
        send_item(MODE_TEST, 12'd4095);
    endtask

    // limit at zero, then raised again so a bit stored above it shows up
    task automatic test_limit_edges();
        write_limit('0);
        send_item(MODE_SET, 12'd0);
        send_item(MODE_SET, 12'd1);
        send_item(MODE_TEST, 12'd4095);
        send_item(MODE_RANK, 12'd0);
        send_item(MODE_CLEAR, 12'd4095);
        write_limit(MAX_VALUE_RST);
        send_item(MODE_TEST, 12'd4095);
        send_item(MODE_RANK, 12'd4095);
    endtask

    task automatic test_random_ops(input logic [VALUE_W-1:0] lim, input int count, input bit quiet);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] v;
        t_mode              op;
        int                 pick;
        write_limit(lim);
        sender_idles   = !quiet && ($urandom_range(0, 3) != 0);
        receiver_idles = !quiet && ($urandom_range(0, 3) != 0);
        base = 12'($urandom_range(0, (lim > 1023) ? 1023 : lim));
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 55)
                v = 12'(base + $urandom_range(0, 63));
            else if (pick < 70)
                v = 12'(lim + $urandom_range(0, 4) - 2);
            else
                v = 12'($urandom_range(0, 4095));
            pick = $urandom_range(0, 99);
            if (n < count / 4)
                pick = pick / 2;
            op = (pick < 35) ? MODE_SET : (pick < 55) ? MODE_RANK :
                 (pick < 75) ? MODE_TEST : MODE_CLEAR;
            send_item(op, v);
        end
    endtask

    initial begin
        for (int i = 0; i < WORD_COUNT; i++)
            member_words[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_limit_edges();
        test_random_ops(12'd4095, 130, 1'b0);
        test_random_ops(12'd1234, 120, 1'b0);
        test_random_ops(12'd63, 110, 1'b0);
        test_random_ops(12'd2900, 120, 1'b0);
        test_random_ops(12'd4095, 120, 1'b1);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/rb_pkg.sv
design/rank_bitmap.sv
design/rb_chk.sv
dv/rank_bitmap_tb.sv
